// ----- hw/rtl/pip_pkg.sv -----
// ----------------------------------------------------------------------------
// pip_pkg: shared types for the point-in-polygon test
// Coordinate types, item codes and the token that walks the cell chain.
// ----------------------------------------------------------------------------
package pip_pkg;

	localparam int LAT_W = 31;
	localparam int LON_W = 32;
	localparam int CNT_W = 4;
	localparam int PROD_W = 64;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef logic signed [LAT_W-1:0] lat_t;
	typedef logic signed [LON_W-1:0] lon_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef struct packed {
		logic valid;
		logic parity;
		logic [LAT_W-1:0] lat;
		logic [LON_W-1:0] lon;
	} token_t;

endpackage

// ----- hw/rtl/pip_cell.sv -----
// ----------------------------------------------------------------------------
// pip_cell: one vertex cell of the ray-casting chain
// Holds one vertex, tests the edge to its predecessor against the passing
// query point and hands the point with the updated parity to the next cell.
// ----------------------------------------------------------------------------
module pip_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic            wr_en,
	input  pip_pkg::lat_t   wr_lat,
	input  pip_pkg::lon_t   wr_lon,
	input  logic            active,
	input  pip_pkg::lat_t   prev_lat,
	input  pip_pkg::lon_t   prev_lon,
	output pip_pkg::lat_t   vtx_lat,
	output pip_pkg::lon_t   vtx_lon,
	input  pip_pkg::token_t tok_in,
	output pip_pkg::token_t tok_out
);

	localparam int FULL_W = pip_pkg::LON_W + pip_pkg::LAT_W + 2;

	pip_pkg::lat_t lat_q;
	pip_pkg::lon_t lon_q;

	logic                  valid_s1;
	logic                  parity_s1;
	logic                  straddle_s1;
	logic                  dpos_s1;
	logic [pip_pkg::LAT_W-1:0] lat_s1;
	logic [pip_pkg::LON_W-1:0] lon_s1;
	pip_pkg::prod_t        lhs_s1;
	pip_pkg::prod_t        rhs_s1;

	pip_pkg::lat_t         p_lat;
	pip_pkg::lon_t         p_lon;
	logic                  straddle;
	logic signed [pip_pkg::LAT_W:0]   dlat;
	logic signed [pip_pkg::LAT_W:0]   dplat;
	logic signed [pip_pkg::LON_W:0]   dlon;
	logic signed [pip_pkg::LON_W:0]   dblon;
	logic signed [FULL_W-1:0] lhs_full;
	logic signed [FULL_W-1:0] rhs_full;
	logic                  left;

	always_comb begin
		p_lat    = pip_pkg::lat_t'(tok_in.lat);
		p_lon    = pip_pkg::lon_t'(tok_in.lon);
		straddle = active & ((lat_q > p_lat) != (prev_lat > p_lat));
		dlat     = $signed({prev_lat[pip_pkg::LAT_W-1], prev_lat})
		         - $signed({lat_q[pip_pkg::LAT_W-1], lat_q});
		dplat    = $signed({p_lat[pip_pkg::LAT_W-1], p_lat})
		         - $signed({lat_q[pip_pkg::LAT_W-1], lat_q});
		dlon     = $signed({p_lon[pip_pkg::LON_W-1], p_lon})
		         - $signed({lon_q[pip_pkg::LON_W-1], lon_q});
		dblon    = $signed({prev_lon[pip_pkg::LON_W-1], prev_lon})
		         - $signed({lon_q[pip_pkg::LON_W-1], lon_q});
		lhs_full = FULL_W'(dlon) * FULL_W'(dlat);
		rhs_full = FULL_W'(dblon) * FULL_W'(dplat);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			lat_q <= wr_lat;
			lon_q <= wr_lon;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			parity_s1   <= tok_in.parity;
			straddle_s1 <= straddle;
			dpos_s1     <= (dlat > 0);
			lat_s1      <= tok_in.lat;
			lon_s1      <= tok_in.lon;
			lhs_s1      <= pip_pkg::prod_t'(lhs_full[pip_pkg::PROD_W-1:0]);
			rhs_s1      <= pip_pkg::prod_t'(rhs_full[pip_pkg::PROD_W-1:0]);
		end
	end

	assign left = dpos_s1 ? (lhs_s1 < rhs_s1) : (lhs_s1 > rhs_s1);

	always_comb begin
		tok_out.valid  = valid_s1;
		tok_out.parity = parity_s1 ^ (straddle_s1 & left);
		tok_out.lat    = lat_s1;
		tok_out.lon    = lon_s1;
	end

	assign vtx_lat = lat_q;
	assign vtx_lon = lon_q;

endmodule

// ----- hw/rtl/point_in_polygon_test.sv -----
// A query point passes through the register of each vertex cell in turn and then
// through the output register; the chain holds while a result waits in the stalled
// output register. No query or vertex write is accepted while a query is in the chain.
// Reset clears the vertex count, the chain valid bits and the output valid flag;
// vertex storage holds no reset value and must be written before use.
// ----------------------------------------------------------------------------
// point_in_polygon_test: even-odd ray-casting geofence
// Vertex writes land in a row of cells; a query point walks the row, each
// cell toggling parity when its edge crosses the ray at a greater longitude than the point.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
	parameter int MAX_VERTICES = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [pip_pkg::CNT_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        opcode,
	input  logic [2:0]                  vertex_index,
	input  logic signed [pip_pkg::LAT_W-1:0] point_latitude,
	input  logic signed [pip_pkg::LON_W-1:0] point_longitude,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        inside_res
);

	localparam int CW = ($clog2(MAX_VERTICES + 1) > pip_pkg::CNT_W) ?
	                    $clog2(MAX_VERTICES + 1) : pip_pkg::CNT_W;
	localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

	logic [pip_pkg::CNT_W-1:0] vertex_count_q;
	logic                      out_valid_q;
	logic                      inside_q;

	logic [CW-1:0]             n_ext;
	logic [CW-1:0]             n_sat;
	logic                      n_ok;
	logic [IW-1:0]             last_idx;
	logic                      in_accept;
	logic                      advance;
	logic                      busy;

	pip_pkg::token_t           tok [MAX_VERTICES+1];
	pip_pkg::lat_t             vtx_lat [MAX_VERTICES];
	pip_pkg::lon_t             vtx_lon [MAX_VERTICES];
	logic [MAX_VERTICES-1:0]   chain_valid;

	assign n_ext    = CW'(vertex_count_q);
	assign n_sat    = (n_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : n_ext;
	assign n_ok     = (n_sat >= CW'(3));
	assign last_idx = IW'(n_sat - CW'(1));

	assign busy      = |chain_valid;
	assign in_stall  = busy;
	assign in_accept = in_valid & ~busy;
	assign advance   = ~(tok[MAX_VERTICES].valid & out_valid_q & out_stall);

	always_comb begin
		tok[0].valid  = in_accept & (opcode == pip_pkg::OP_QUERY);
		tok[0].parity = 1'b0;
		tok[0].lat    = point_latitude;
		tok[0].lon    = point_longitude;
	end

	for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
		pip_pkg::lat_t prev_lat;
		pip_pkg::lon_t prev_lon;
		logic          wr_en;

		if (k == 0) begin : g_wrap
			assign prev_lat = vtx_lat[last_idx];
			assign prev_lon = vtx_lon[last_idx];
		end else begin : g_link
			assign prev_lat = vtx_lat[k-1];
			assign prev_lon = vtx_lon[k-1];
		end

		assign wr_en = in_accept & (opcode == pip_pkg::OP_WRITE)
		             & ({29'd0, vertex_index} == 32'(k));
		assign chain_valid[k] = tok[k+1].valid;

		pip_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.wr_en    (wr_en),
			.wr_lat   (point_latitude),
			.wr_lon   (point_longitude),
			.active   (CW'(k) < n_sat),
			.prev_lat (prev_lat),
			.prev_lon (prev_lon),
			.vtx_lat  (vtx_lat[k]),
			.vtx_lon  (vtx_lon[k]),
			.tok_in   (tok[k]),
			.tok_out  (tok[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (cfg_we) begin
			vertex_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tok[MAX_VERTICES].valid && advance) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok[MAX_VERTICES].valid && advance) begin
			inside_q <= tok[MAX_VERTICES].parity & n_ok;
		end
	end

	assign out_valid  = out_valid_q;
	assign inside_res = inside_q;

endmodule
